>>> rtl/atdw_pkg.sv
// atdw_pkg: shared types, constants and counting helpers of the display width meter
package atdw_pkg;

    // counts stop at the lesser of the configured maximum and the 16-bit range
    localparam logic [31:0] MAX_COUNT   = 32'd65535;
    localparam logic [15:0] COUNT_LIMIT = (MAX_COUNT > 32'd65535) ? 16'hFFFF : MAX_COUNT[15:0];

    // byte codes that steer the escape parser
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_M      = 8'h6D;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2
    } esc_phase_t;

    typedef struct packed {
        esc_phase_t  phase;
        logic [15:0] pending;
        logic [15:0] line_bytes;
        logic [15:0] line_display;
        logic [15:0] byte_total;
        logic [15:0] display_total;
        logic [15:0] lines_seen;
        logic [15:0] widest_bytes;
        logic [15:0] widest_display;
    } meter_state_t;

    typedef struct packed {
        logic [15:0] total_bytes;
        logic [15:0] total_display;
        logic [15:0] line_count;
        logic [15:0] max_line_bytes;
        logic [15:0] max_line_display;
    } meter_result_t;

    localparam meter_state_t STATE_CLEAR = '{
        phase:          PH_IDLE,
        pending:        16'd0,
        line_bytes:     16'd0,
        line_display:   16'd0,
        byte_total:     16'd0,
        display_total:  16'd0,
        lines_seen:     16'd0,
        widest_bytes:   16'd0,
        widest_display: 16'd0
    };

    // saturating add of two counts
    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[15:0];
    endfunction

    // saturating increment
    function automatic logic [15:0] sat_inc(input logic [15:0] a);
        return sat_add(a, 16'd1);
    endfunction

    // an open sequence that breaks off shows its pending bytes
    function automatic meter_state_t flush_pending(input meter_state_t s);
        meter_state_t r;
        r = s;
        if (s.phase != PH_IDLE)
        begin
            r.line_display  = sat_add(s.line_display, s.pending);
            r.display_total = sat_add(s.display_total, s.pending);
        end
        r.phase   = PH_IDLE;
        r.pending = 16'd0;
        return r;
    endfunction

    // end of a line: fold a non-empty line into the line statistics
    function automatic meter_state_t close_line(input meter_state_t s);
        meter_state_t r;
        r = s;
        if (s.line_bytes != 16'd0)
        begin
            r.lines_seen = sat_inc(s.lines_seen);
            if (s.line_bytes > s.widest_bytes)
            begin
                r.widest_bytes = s.line_bytes;
            end
            if (s.line_display > s.widest_display)
            begin
                r.widest_display = s.line_display;
            end
        end
        r.line_bytes   = 16'd0;
        r.line_display = 16'd0;
        return r;
    endfunction

endpackage

>>> rtl/ansi_text_display_width_meter.sv
// ansi_text_display_width_meter: byte-stream meter of text width with color sequences skipped
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------------
//  in      | input     | in_valid / in_stall | text_byte, is_last
//  out     | output    | out_valid/out_stall | total_bytes, total_display, line_count,
//          |           |                     | max_line_bytes, max_line_display
//
// One byte per cycle while in_stall is low: a byte sits in the input register, then the parser
// and counter update runs from it into the state and result registers.
// A last byte waits in the input register; its result is then held in the result register until taken.
// The input stalls only while a last byte waits and the result register is full and stalled.
// Reset clears the parser, all counters and both valid flags.
module ansi_text_display_width_meter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] total_bytes,
    output logic [15:0] total_display,
    output logic [15:0] line_count,
    output logic [15:0] max_line_bytes,
    output logic [15:0] max_line_display
);
    import atdw_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;
    meter_state_t  state_reg;
    meter_state_t  state_next;
    meter_result_t result_next;
    meter_result_t result_reg;
    logic          out_valid_reg;
    logic          advance;
    logic          accept;

    // the held byte moves on unless it ends a string and the result slot is blocked
    assign advance  = in_valid_reg && !(last_reg && out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    atdw_step u_step (
        .cur_state  (state_reg),
        .text_byte  (byte_reg),
        .is_last    (last_reg),
        .next_state (state_next),
        .result     (result_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text_byte;
            last_reg <= is_last;
        end
    end

    // parser and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign total_bytes      = result_reg.total_bytes;
    assign total_display    = result_reg.total_display;
    assign line_count       = result_reg.line_count;
    assign max_line_bytes   = result_reg.max_line_bytes;
    assign max_line_display = result_reg.max_line_display;

    // no open sequence means nothing pending
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) |-> (state_reg.pending == 16'd0))
        else $error("pending bytes without an open sequence");

    // a lone escape byte is exactly one pending byte
    a_esc_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_ESC) |-> (state_reg.pending == 16'd1))
        else $error("escape phase with wrong pending count");

    // a line never shows more than it holds
    a_line_width: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.line_display <= state_reg.line_bytes))
        else $error("line display width exceeds line bytes");

    // counters start clean after a string ends
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (state_reg.byte_total == 16'd0 && out_valid_reg))
        else $error("state not cleared or result missing after last byte");

    // the input only stalls behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && last_reg))
        else $error("input stalled without a blocked result");

endmodule

>>> rtl/atdw_step.sv
// atdw_step: one-byte update of the parser and counters, plus the end-of-string result
module atdw_step (
    input  atdw_pkg::meter_state_t  cur_state,
    input  logic [7:0]              text_byte,
    input  logic                    is_last,
    output atdw_pkg::meter_state_t  next_state,
    output atdw_pkg::meter_result_t result
);
    import atdw_pkg::*;

    meter_state_t s;
    meter_state_t fin;
    logic         handled;
    logic         is_param;

    assign is_param = ((text_byte >= CH_ZERO) && (text_byte <= CH_NINE)) || (text_byte == CH_SEMI);

    // byte update following the escape parser
    always_comb
    begin
        s       = cur_state;
        handled = 1'b0;
        s.byte_total = sat_inc(cur_state.byte_total);
        if (text_byte == CH_LF)
        begin
            s = flush_pending(s);
            s.display_total = sat_inc(s.display_total);
            s = close_line(s);
        end
        else
        begin
            s.line_bytes = sat_inc(s.line_bytes);
            if (s.phase == PH_ESC)
            begin
                if (text_byte == CH_LBRACK)
                begin
                    s.phase   = PH_PARAM;
                    s.pending = sat_inc(s.pending);
                    handled   = 1'b1;
                end
                else
                begin
                    s = flush_pending(s);
                end
            end
            else if (s.phase == PH_PARAM)
            begin
                if (is_param)
                begin
                    s.pending = sat_inc(s.pending);
                    handled   = 1'b1;
                end
                else if (text_byte == CH_M)
                begin
                    s.phase   = PH_IDLE;
                    s.pending = 16'd0;
                    handled   = 1'b1;
                end
                else
                begin
                    s = flush_pending(s);
                end
            end
            if (!handled)
            begin
                if (text_byte == CH_ESC)
                begin
                    s.phase   = PH_ESC;
                    s.pending = 16'd1;
                end
                else
                begin
                    s.line_display  = sat_inc(s.line_display);
                    s.display_total = sat_inc(s.display_total);
                end
            end
        end
    end

    // last byte: close out the string and start clean
    always_comb
    begin
        fin = close_line(flush_pending(s));
        result.total_bytes      = fin.byte_total;
        result.total_display    = fin.display_total;
        result.line_count       = fin.lines_seen;
        result.max_line_bytes   = fin.widest_bytes;
        result.max_line_display = fin.widest_display;
        next_state = is_last ? STATE_CLEAR : s;
    end

endmodule

>>> tb/ansi_text_display_width_meter_chk.sv
// checker for the text width meter: watches both channels, predicts measurements, compares them
`timescale 1ns / 1ps

module ansi_text_display_width_meter_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        is_last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] total_bytes,
    input  logic [15:0] total_display,
    input  logic [15:0] line_count,
    input  logic [15:0] max_line_bytes,
    input  logic [15:0] max_line_display,
    output int          fail_count,
    output int          outstanding,
    output int          checked_count
);
    import atdw_pkg::*;

    // predicted parser and counter state
    esc_phase_t    esc_state;
    logic [15:0]   seq_len;
    logic [15:0]   cur_bytes;
    logic [15:0]   cur_width;
    logic [15:0]   str_bytes;
    logic [15:0]   str_width;
    logic [15:0]   line_total;
    logic [15:0]   longest_bytes;
    logic [15:0]   widest_width;

    // measurements still owed by the block, oldest first
    meter_result_t awaited_measures[$];
    int            fails;
    int            checked;

    // count addition that sticks at the limit
    function automatic logic [15:0] capped_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned sum;
        sum = 32'(a) + 32'(b);
        if (sum > 32'(COUNT_LIMIT))
        begin
            sum = 32'(COUNT_LIMIT);
        end
        return sum[15:0];
    endfunction

    task clear_meter;
        esc_state     = PH_IDLE;
        seq_len       = 16'd0;
        cur_bytes     = 16'd0;
        cur_width     = 16'd0;
        str_bytes     = 16'd0;
        str_width     = 16'd0;
        line_total    = 16'd0;
        longest_bytes = 16'd0;
        widest_width  = 16'd0;
    endtask

    // an unfinished color sequence becomes visible text
    task reveal_sequence;
        if (esc_state != PH_IDLE)
        begin
            cur_width = capped_add(cur_width, seq_len);
            str_width = capped_add(str_width, seq_len);
        end
        esc_state = PH_IDLE;
        seq_len   = 16'd0;
    endtask

    // empty lines leave the line statistics alone
    task finish_line;
        if (cur_bytes != 16'd0)
        begin
            line_total = capped_add(line_total, 16'd1);
            if (cur_bytes > longest_bytes)
            begin
                longest_bytes = cur_bytes;
            end
            if (cur_width > widest_width)
            begin
                widest_width = cur_width;
            end
        end
        cur_bytes = 16'd0;
        cur_width = 16'd0;
    endtask

    // one text byte through the parser
    task measure_byte(input logic [7:0] b);
        str_bytes = capped_add(str_bytes, 16'd1);
        if (b == CH_LF)
        begin
            reveal_sequence();
            str_width = capped_add(str_width, 16'd1);
            finish_line();
            return;
        end
        cur_bytes = capped_add(cur_bytes, 16'd1);
        if (esc_state == PH_ESC)
        begin
            if (b == CH_LBRACK)
            begin
                esc_state = PH_PARAM;
                seq_len   = capped_add(seq_len, 16'd1);
                return;
            end
            reveal_sequence();
        end
        else if (esc_state == PH_PARAM)
        begin
            if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI)
            begin
                seq_len = capped_add(seq_len, 16'd1);
                return;
            end
            if (b == CH_M)
            begin
                esc_state = PH_IDLE;
                seq_len   = 16'd0;
                return;
            end
            reveal_sequence();
        end
        // the breaking byte starts over from idle
        if (b == CH_ESC)
        begin
            esc_state = PH_ESC;
            seq_len   = 16'd1;
        end
        else
        begin
            cur_width = capped_add(cur_width, 16'd1);
            str_width = capped_add(str_width, 16'd1);
        end
    endtask

    task compare_field(input string name, input logic [15:0] want, input logic [15:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fails++;
        end
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        meter_result_t want;
        if (!rst_n)
        begin
            clear_meter();
            awaited_measures.delete();
            fails         = 0;
            checked       = 0;
            fail_count    <= 0;
            outstanding   <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                measure_byte(text_byte);
                if (is_last)
                begin
                    reveal_sequence();
                    finish_line();
                    want.total_bytes      = str_bytes;
                    want.total_display    = str_width;
                    want.line_count       = line_total;
                    want.max_line_bytes   = longest_bytes;
                    want.max_line_display = widest_width;
                    awaited_measures.push_back(want);
                    clear_meter();
                end
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_measures.size() == 0)
                begin
                    $error("measurement delivered with none outstanding");
                    fails++;
                end
                else
                begin
                    want = awaited_measures.pop_front();
                    compare_field("total_bytes", want.total_bytes, total_bytes);
                    compare_field("total_display", want.total_display, total_display);
                    compare_field("line_count", want.line_count, line_count);
                    compare_field("max_line_bytes", want.max_line_bytes, max_line_bytes);
                    compare_field("max_line_display", want.max_line_display,
                                  max_line_display);
                    checked++;
                end
            end
            fail_count    <= fails;
            outstanding   <= awaited_measures.size();
            checked_count <= checked;
        end
    end

endmodule

>>> tb/ansi_text_display_width_meter_tb.sv
// testbench top for the text width meter: clock, reset, text stimulus, idling and verdict
`timescale 1ns / 1ps

module ansi_text_display_width_meter_tb;
    import atdw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] total_bytes;
    logic [15:0] total_display;
    logic [15:0] line_count;
    logic [15:0] max_line_bytes;
    logic [15:0] max_line_display;

    int          fail_count;
    int          outstanding;
    int          checked_count;

    int          send_idle;
    int          recv_idle;
    int          bytes_sent;
    int          strings_sent;
    int unsigned cycle_count = 0;
    logic [7:0]  text_buf[$];

    ansi_text_display_width_meter u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .text_byte        (text_byte),
        .is_last          (is_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .total_bytes      (total_bytes),
        .total_display    (total_display),
        .line_count       (line_count),
        .max_line_bytes   (max_line_bytes),
        .max_line_display (max_line_display)
    );

    ansi_text_display_width_meter_chk u_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .text_byte        (text_byte),
        .is_last          (is_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .total_bytes      (total_bytes),
        .total_display    (total_display),
        .line_count       (line_count),
        .max_line_bytes   (max_line_bytes),
        .max_line_display (max_line_display),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .checked_count    (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ansi_text_display_width_meter_tb NOT OK");
            $finish;
        end
    end

    // result side stalls at random
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // one byte request, with optional idle cycles ahead of it
    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        is_last   <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            push_byte(text_buf[i], i == text_buf.size() - 1);
        end
        strings_sent++;
    endtask

    function automatic logic [7:0] param_char();
        if ($urandom_range(9) == 0)
        begin
            return CH_SEMI;
        end
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    // one piece of text: plain run, newlines, color sequence, broken sequence or noise
    function automatic void add_token();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            n = $urandom_range(1, 8);
            repeat (n) text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        else if (pick < 45)
        begin
            n = $urandom_range(1, 3);
            repeat (n) text_buf.push_back(CH_LF);
        end
        else if (pick < 70)
        begin
            text_buf.push_back(CH_ESC);
            text_buf.push_back(CH_LBRACK);
            n = $urandom_range(0, 5);
            repeat (n) text_buf.push_back(param_char());
            text_buf.push_back(CH_M);
        end
        else if (pick < 85)
        begin
            text_buf.push_back(CH_ESC);
            if ($urandom_range(1))
            begin
                text_buf.push_back(CH_LBRACK);
                n = $urandom_range(0, 4);
                repeat (n) text_buf.push_back(param_char());
            end
            // breaking byte, sometimes left out so the next piece breaks it
            case ($urandom_range(4))
                0: text_buf.push_back(CH_LF);
                1: text_buf.push_back(CH_ESC);
                2: text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
                3: text_buf.push_back(8'($urandom_range(255)));
                default: ;
            endcase
        end
        else
        begin
            text_buf.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic run_random(input int budget);
        int start;
        int pieces;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            text_buf.delete();
            pieces = $urandom_range(1, 8);
            if ($urandom_range(19) == 0)
            begin
                pieces = $urandom_range(20, 40);
            end
            repeat (pieces) add_token();
            send_text();
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        text_byte    = 8'h00;
        is_last      = 1'b0;
        send_idle    = 31;
        recv_idle    = 71;
        bytes_sent   = 0;
        strings_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // complete color sequence, then visible text
        text_buf = {CH_ESC, CH_LBRACK, 8'h33, 8'h31, CH_M, 8'h41};
        send_text();
        // sequences broken by text and newline, zero and top bytes, empty lines,
        // sequence still open at the last byte
        text_buf = {CH_ESC, 8'h78, CH_ESC, CH_LBRACK, CH_NINE, CH_LF, 8'h00, 8'hFF,
                    CH_ESC, CH_LBRACK, 8'h34, CH_SEMI, 8'h71, CH_LF, CH_LF,
                    CH_ESC, CH_LBRACK};
        send_text();
        // escape broken by a new escape, empty parameter list
        text_buf = {CH_ESC, CH_ESC, CH_LBRACK, CH_M};
        send_text();
        // lone newline
        text_buf = {CH_LF};
        send_text();

        run_random(600);
        send_idle = 71;
        recv_idle = 31;
        run_random(600);
        send_idle = 0;
        recv_idle = 0;
        run_random(600);
        in_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("covered %0d text bytes in %0d strings, %0d measurements compared",
                 bytes_sent, strings_sent, checked_count);
        $display("mix: color and broken sequences, stray bytes, empty lines, stalls");
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("ansi_text_display_width_meter_tb OK");
        end
        else
        begin
            $display("ansi_text_display_width_meter_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/atdw_pkg.sv
rtl/atdw_step.sv
rtl/ansi_text_display_width_meter.sv
tb/ansi_text_display_width_meter_chk.sv
tb/ansi_text_display_width_meter_tb.sv
